### sv/tmd_pkg.sv
// Package for the typed message deframer.
// Holds the header tag values, field codes and the result record type.
// Depends on nothing; used by every module of the deframer.
package tmd_pkg;

    localparam logic [31:0] TAG_STR_STR    = 32'h00AB_CDEF;
    localparam logic [31:0] TAG_STR_INT    = 32'h00AB_CDEE;
    localparam logic [31:0] TAG_STR_DOUBLE = 32'h00AB_CDEC;
    localparam logic [31:0] TAG_COMMAND    = 32'h00AB_CDED;

    localparam logic [1:0] TYPE_STR_STR    = 2'd0;
    localparam logic [1:0] TYPE_STR_INT    = 2'd1;
    localparam logic [1:0] TYPE_STR_DOUBLE = 2'd2;
    localparam logic [1:0] TYPE_COMMAND    = 2'd3;

    localparam logic [1:0] PART_KEY   = 2'd0;
    localparam logic [1:0] PART_VALUE = 2'd1;
    localparam logic [1:0] PART_WORD  = 2'd2;
    localparam logic [1:0] PART_NONE  = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BAD_TAG = 2'd1;
    localparam logic [1:0] ERR_SHORT   = 2'd2;

    localparam logic [31:0] MIN_LEN_COMMAND = 32'd12;
    localparam logic [31:0] MIN_LEN_KEYED   = 32'd16;
    localparam logic [31:0] INT_BYTES       = 32'd4;
    localparam logic [31:0] DOUBLE_BYTES    = 32'd8;
    localparam logic [31:0] CMD_BYTES       = 32'd4;

    typedef struct packed {
        logic [1:0]  msg_type;
        logic [1:0]  part;
        logic [63:0] payload;
        logic        end_of_message;
        logic [1:0]  error;
    } result_t;

endpackage

### sv/typed_message_deframer_core.sv
// Top level of the typed message deframer.
// Connects the parser, the result queue and the output stage.
// Depends on tmd_pkg, tmd_front, tmd_queue and tmd_back.
//
//  Channel  Direction  Transaction
//  s_       in         one received stream byte
//  m_       out        one key byte, string byte, value word or end marker
//
// One byte is taken every clock while the queue has room; its result, if any,
// enters the queue at the edge that accepts the byte and reaches m_ through the
// output register. The queue of QUEUE_DEPTH entries absorbs stalls on m_, and
// s_tready falls only while it is full.
// A synchronous active-low reset clears the parser, the queue and the output.
// After an error the block keeps taking bytes and drops them until reset.
module typed_message_deframer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // payload[63:0], error[65:64], zero[71:66]
    output logic [3:0]  m_tuser,   // msg_type[1:0], part[3:2]
    output logic        m_tlast
);

    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             res_valid;
    tmd_pkg::result_t res;
    tmd_pkg::result_t q_data;

    assign s_tready = !q_full;

    tmd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid && s_tready),
        .byte_data  (s_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    tmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    tmd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sv/tmd_front.sv
// Front end of the typed message deframer: parses the byte stream.
// Tracks the segment header, counts content bytes and builds result records.
// Depends on tmd_pkg.
module tmd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_valid,
    input  logic [7:0]       byte_data,
    output logic             res_valid,
    output tmd_pkg::result_t res
);

    logic [31:0] pos_reg, pos_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] seg_len_reg, seg_len_next;
    logic [31:0] key_len_reg, key_len_next;
    logic [31:0] val_len_reg, val_len_next;
    logic [63:0] acc_reg, acc_next;
    logic        halted_reg, halted_next;
    logic [1:0]  type_reg, type_next;
    logic [31:0] key_rem_reg, key_rem_next;
    logic [31:0] val_rem_reg, val_rem_next;
    logic [2:0]  wcnt_reg, wcnt_next;

    logic        hi_zero;
    logic [3:0]  lo;
    logic [4:0]  lane_sh;
    logic        have;
    logic        stop;
    logic        content;
    logic [32:0] pos_inc;
    logic [33:0] need;
    logic [31:0] addend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            tag_reg     <= '0;
            seg_len_reg <= '0;
            key_len_reg <= '0;
            val_len_reg <= '0;
            acc_reg     <= '0;
            halted_reg  <= 1'b0;
            type_reg    <= tmd_pkg::TYPE_STR_STR;
            key_rem_reg <= '0;
            val_rem_reg <= '0;
            wcnt_reg    <= '0;
        end else begin
            pos_reg     <= pos_next;
            tag_reg     <= tag_next;
            seg_len_reg <= seg_len_next;
            key_len_reg <= key_len_next;
            val_len_reg <= val_len_next;
            acc_reg     <= acc_next;
            halted_reg  <= halted_next;
            type_reg    <= type_next;
            key_rem_reg <= key_rem_next;
            val_rem_reg <= val_rem_next;
            wcnt_reg    <= wcnt_next;
        end
    end

    always_comb begin
        pos_next     = pos_reg;
        tag_next     = tag_reg;
        seg_len_next = seg_len_reg;
        key_len_next = key_len_reg;
        val_len_next = val_len_reg;
        acc_next     = acc_reg;
        halted_next  = halted_reg;
        type_next    = type_reg;
        key_rem_next = key_rem_reg;
        val_rem_next = val_rem_reg;
        wcnt_next    = wcnt_reg;

        res_valid          = 1'b0;
        res.msg_type       = type_reg;
        res.part           = tmd_pkg::PART_NONE;
        res.payload        = '0;
        res.end_of_message = 1'b0;
        res.error          = tmd_pkg::ERR_NONE;

        hi_zero = (pos_reg[31:4] == 28'd0);
        lo      = pos_reg[3:0];
        lane_sh = {lo[1:0], 3'b000};
        have    = 1'b0;
        stop    = 1'b0;
        content = 1'b0;
        pos_inc = {1'b0, pos_reg} + 33'd1;
        addend  = '0;
        need    = '0;

        if (byte_valid && !halted_reg) begin
            if (hi_zero && lo < 4'd4) begin
                if (lo[1:0] == 2'd0) begin
                    tag_next = '0;
                end
                tag_next[lane_sh +: 8] = byte_data;
                acc_next = '0;
                if (lo == 4'd3) begin
                    case (tag_next)
                        tmd_pkg::TAG_STR_STR:    type_next = tmd_pkg::TYPE_STR_STR;
                        tmd_pkg::TAG_STR_INT:    type_next = tmd_pkg::TYPE_STR_INT;
                        tmd_pkg::TAG_STR_DOUBLE: type_next = tmd_pkg::TYPE_STR_DOUBLE;
                        tmd_pkg::TAG_COMMAND:    type_next = tmd_pkg::TYPE_COMMAND;
                        default: begin
                            halted_next  = 1'b1;
                            stop         = 1'b1;
                            res_valid    = 1'b1;
                            res.msg_type = tmd_pkg::TYPE_STR_STR;
                            res.error    = tmd_pkg::ERR_BAD_TAG;
                        end
                    endcase
                end
            end else if (hi_zero && lo < 4'd8) begin
                if (lo[1:0] == 2'd0) begin
                    seg_len_next = '0;
                end
                seg_len_next[lane_sh +: 8] = byte_data;
                if (lo == 4'd7) begin
                    if (seg_len_next < ((type_reg == tmd_pkg::TYPE_COMMAND) ?
                                        tmd_pkg::MIN_LEN_COMMAND :
                                        tmd_pkg::MIN_LEN_KEYED)) begin
                        halted_next = 1'b1;
                        stop        = 1'b1;
                        res_valid   = 1'b1;
                        res.error   = tmd_pkg::ERR_SHORT;
                    end else if (type_reg == tmd_pkg::TYPE_COMMAND) begin
                        key_rem_next = '0;
                        val_rem_next = tmd_pkg::CMD_BYTES;
                        wcnt_next    = '0;
                    end
                end
            end else if (type_reg == tmd_pkg::TYPE_COMMAND) begin
                content = 1'b1;
            end else if (hi_zero && lo < 4'd12) begin
                if (lo[1:0] == 2'd0) begin
                    key_len_next = '0;
                end
                key_len_next[lane_sh +: 8] = byte_data;
            end else if (hi_zero) begin
                if (lo[1:0] == 2'd0) begin
                    val_len_next = '0;
                end
                val_len_next[lane_sh +: 8] = byte_data;
                if (lo == 4'd15) begin
                    case (type_reg)
                        tmd_pkg::TYPE_STR_STR:   addend = val_len_next;
                        tmd_pkg::TYPE_STR_INT:   addend = tmd_pkg::INT_BYTES;
                        default:                 addend = tmd_pkg::DOUBLE_BYTES;
                    endcase
                    need = {2'b00, tmd_pkg::MIN_LEN_KEYED} + {2'b00, key_len_reg}
                         + {2'b00, addend};
                    if (need > {2'b00, seg_len_reg}) begin
                        halted_next = 1'b1;
                        stop        = 1'b1;
                        res_valid   = 1'b1;
                        res.error   = tmd_pkg::ERR_SHORT;
                    end else begin
                        key_rem_next = key_len_reg;
                        val_rem_next = addend;
                        wcnt_next    = '0;
                    end
                end
            end else begin
                content = 1'b1;
            end

            if (content) begin
                if (key_rem_reg != 32'd0) begin
                    have         = 1'b1;
                    res.part     = tmd_pkg::PART_KEY;
                    res.payload  = {56'd0, byte_data};
                    key_rem_next = key_rem_reg - 32'd1;
                end else if (val_rem_reg != 32'd0) begin
                    val_rem_next = val_rem_reg - 32'd1;
                    if (type_reg == tmd_pkg::TYPE_STR_STR) begin
                        have        = 1'b1;
                        res.part    = tmd_pkg::PART_VALUE;
                        res.payload = {56'd0, byte_data};
                    end else begin
                        acc_next[{wcnt_reg, 3'b000} +: 8] = byte_data;
                        wcnt_next = wcnt_reg + 3'd1;
                        if (val_rem_reg == 32'd1) begin
                            have        = 1'b1;
                            res.part    = tmd_pkg::PART_WORD;
                            res.payload = acc_next;
                        end
                    end
                end
            end

            if (!stop) begin
                if (!(hi_zero && lo < 4'd8) && pos_inc == {1'b0, seg_len_reg}) begin
                    pos_next           = '0;
                    res_valid          = 1'b1;
                    res.end_of_message = 1'b1;
                end else begin
                    pos_next  = pos_inc[31:0];
                    res_valid = have;
                end
            end
        end
    end

endmodule

### sv/tmd_queue.sv
// Result queue of the typed message deframer.
// A small first-in first-out buffer between the parser and the output stage.
// Depends on tmd_pkg.
module tmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  tmd_pkg::result_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output tmd_pkg::result_t rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    tmd_pkg::result_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CW'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/tmd_back.sv
// Output stage of the typed message deframer.
// Pulls result records from the queue into the output register of the stream.
// Depends on tmd_pkg.
module tmd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  tmd_pkg::result_t q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,
    output logic [3:0]       m_tuser,
    output logic             m_tlast
);

    logic             valid_reg, valid_next;
    tmd_pkg::result_t data_reg;

    assign q_pop      = !q_empty && (!valid_reg || m_tready);
    assign valid_next = q_pop || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, data_reg.error, data_reg.payload};
    assign m_tuser  = {data_reg.part, data_reg.msg_type};
    assign m_tlast  = data_reg.end_of_message;

endmodule

### tb/sv/typed_message_deframer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for typed_message_deframer_core: sends framed byte streams
// and compares every result with an in-bench model of the segment parser.
// Depends on tmd_pkg and the deframer RTL.
module typed_message_deframer_core_tb;

    localparam int          RESET_CYCLES = 12;
    localparam int          RANDOM_BYTES = 490;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [2:0]  KIND_UNKNOWN = 3'd4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    logic [31:0] seg_pos = '0;
    logic [31:0] seg_tag = '0;
    logic [31:0] seg_len = '0;
    logic [31:0] key_len = '0;
    logic [31:0] val_len = '0;
    logic [63:0] word_acc = '0;
    bit          stopped = 1'b0;

    tmd_pkg::result_t awaited_records[$];
    logic [7:0]  frame_bytes[$];
    int          fault_count = 0;
    int          cycle_count = 0;
    bit          fast_mode = 1'b0;
    bit          hold_pending = 1'b0;

    typed_message_deframer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [2:0] kind_of(input logic [31:0] tag);
        case (tag)
            tmd_pkg::TAG_STR_STR:    return {1'b0, tmd_pkg::TYPE_STR_STR};
            tmd_pkg::TAG_STR_INT:    return {1'b0, tmd_pkg::TYPE_STR_INT};
            tmd_pkg::TAG_STR_DOUBLE: return {1'b0, tmd_pkg::TYPE_STR_DOUBLE};
            tmd_pkg::TAG_COMMAND:    return {1'b0, tmd_pkg::TYPE_COMMAND};
            default:                 return KIND_UNKNOWN;
        endcase
    endfunction

    function automatic logic [31:0] tag_of(input logic [1:0] kind);
        case (kind)
            tmd_pkg::TYPE_STR_STR: return tmd_pkg::TAG_STR_STR;
            tmd_pkg::TYPE_STR_INT: return tmd_pkg::TAG_STR_INT;
            tmd_pkg::TYPE_STR_DOUBLE: return tmd_pkg::TAG_STR_DOUBLE;
            default: return tmd_pkg::TAG_COMMAND;
        endcase
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        frame_bytes.insert(frame_bytes.size(), b);
    endfunction

    function automatic void push_record(input logic [1:0] msg_type, input logic [1:0] part,
                                        input logic [63:0] payload, input logic eom,
                                        input logic [1:0] err);
        tmd_pkg::result_t rec;
        rec.msg_type       = msg_type;
        rec.part           = part;
        rec.payload        = payload;
        rec.end_of_message = eom;
        rec.error          = err;
        awaited_records.insert(awaited_records.size(), rec);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [2:0]  kind;
        logic [1:0]  msg_kind;
        logic [1:0]  lane;
        bit          have;
        logic [1:0]  part;
        logic [63:0] payload;
        logic [63:0] need;
        logic [63:0] off;
        logic [63:0] off2;
        logic [63:0] wbytes;
        if (stopped) return;
        kind     = kind_of(seg_tag);
        msg_kind = kind[1:0];
        lane     = seg_pos[1:0];
        have     = 1'b0;
        part     = tmd_pkg::PART_NONE;
        payload  = '0;
        if (seg_pos < 4) begin
            if (lane == 2'd0) seg_tag = '0;
            seg_tag[8*lane +: 8] = b;
            word_acc = '0;
            if (seg_pos == 3 && kind_of(seg_tag) == KIND_UNKNOWN) begin
                stopped = 1'b1;
                push_record(tmd_pkg::TYPE_STR_STR, tmd_pkg::PART_NONE, '0, 1'b0,
                            tmd_pkg::ERR_BAD_TAG);
                return;
            end
        end else if (seg_pos < 8) begin
            if (lane == 2'd0) seg_len = '0;
            seg_len[8*lane +: 8] = b;
            if (seg_pos == 7) begin
                need = {32'd0, (msg_kind == tmd_pkg::TYPE_COMMAND) ?
                               tmd_pkg::MIN_LEN_COMMAND : tmd_pkg::MIN_LEN_KEYED};
                if ({32'd0, seg_len} < need) begin
                    stopped = 1'b1;
                    push_record(msg_kind, tmd_pkg::PART_NONE, '0, 1'b0, tmd_pkg::ERR_SHORT);
                    return;
                end
            end
        end else if (msg_kind == tmd_pkg::TYPE_COMMAND) begin
            if (seg_pos < 12) begin
                word_acc = word_acc | ({56'd0, b} << (8 * lane));
                if (seg_pos == 11) begin
                    have    = 1'b1;
                    part    = tmd_pkg::PART_WORD;
                    payload = word_acc;
                end
            end
        end else if (seg_pos < 12) begin
            if (lane == 2'd0) key_len = '0;
            key_len[8*lane +: 8] = b;
        end else if (seg_pos < 16) begin
            if (lane == 2'd0) val_len = '0;
            val_len[8*lane +: 8] = b;
            if (seg_pos == 15) begin
                need = {32'd0, tmd_pkg::MIN_LEN_KEYED} + {32'd0, key_len};
                if (msg_kind == tmd_pkg::TYPE_STR_STR) need = need + {32'd0, val_len};
                else if (msg_kind == tmd_pkg::TYPE_STR_INT)
                    need = need + {32'd0, tmd_pkg::INT_BYTES};
                else need = need + {32'd0, tmd_pkg::DOUBLE_BYTES};
                if (need > {32'd0, seg_len}) begin
                    stopped = 1'b1;
                    push_record(msg_kind, tmd_pkg::PART_NONE, '0, 1'b0, tmd_pkg::ERR_SHORT);
                    return;
                end
            end
        end else begin
            off = {32'd0, seg_pos} - 64'd16;
            if (off < {32'd0, key_len}) begin
                have    = 1'b1;
                part    = tmd_pkg::PART_KEY;
                payload = {56'd0, b};
            end else begin
                off2 = off - {32'd0, key_len};
                if (msg_kind == tmd_pkg::TYPE_STR_STR) begin
                    if (off2 < {32'd0, val_len}) begin
                        have    = 1'b1;
                        part    = tmd_pkg::PART_VALUE;
                        payload = {56'd0, b};
                    end
                end else begin
                    wbytes = {32'd0, (msg_kind == tmd_pkg::TYPE_STR_INT) ?
                                     tmd_pkg::INT_BYTES : tmd_pkg::DOUBLE_BYTES};
                    if (off2 < wbytes) begin
                        word_acc = word_acc | ({56'd0, b} << (8 * off2));
                        if (off2 == wbytes - 1) begin
                            have    = 1'b1;
                            part    = tmd_pkg::PART_WORD;
                            payload = word_acc;
                        end
                    end
                end
            end
        end
        if (seg_pos >= 8 && {32'd0, seg_pos} + 64'd1 == {32'd0, seg_len}) begin
            seg_pos = '0;
            push_record(msg_kind, part, payload, 1'b1, tmd_pkg::ERR_NONE);
            return;
        end
        seg_pos = seg_pos + 1;
        if (have) push_record(msg_kind, part, payload, 1'b0, tmd_pkg::ERR_NONE);
    endfunction

    always @(posedge aclk) begin : monitor
        tmd_pkg::result_t got;
        tmd_pkg::result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) deframe_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                got.payload        = m_tdata[63:0];
                got.error          = m_tdata[65:64];
                got.msg_type       = m_tuser[1:0];
                got.part           = m_tuser[3:2];
                got.end_of_message = m_tlast;
                if (awaited_records.size() == 0) begin
                    $error("Result transaction arrived with none expected.");
                    fault_count++;
                end else begin
                    want = awaited_records.pop_front();
                    if (got.msg_type !== want.msg_type) begin
                        $error("msg_type: expected %0d, got %0d", want.msg_type, got.msg_type);
                        fault_count++;
                    end
                    if (got.part !== want.part) begin
                        $error("part: expected %0d, got %0d", want.part, got.part);
                        fault_count++;
                    end
                    if (got.payload !== want.payload) begin
                        $error("payload: expected %h, got %h", want.payload, got.payload);
                        fault_count++;
                    end
                    if (got.end_of_message !== want.end_of_message) begin
                        $error("end_of_message: expected %0d, got %0d",
                               want.end_of_message, got.end_of_message);
                        fault_count++;
                    end
                    if (got.error !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, got.error);
                        fault_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver stalls at random; a pending hold keeps it stalled long enough
    // for the result queue to fill and stop the input.
    initial begin : result_sink
        int stall;
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = fast_mode ? 0 : $urandom_range(0, 10);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    function automatic void push_word32(input logic [31:0] w);
        for (int i = 0; i < 4; i++) append_byte(w[8*i +: 8]);
    endfunction

    function automatic void push_random(input int n);
        for (int i = 0; i < n; i++) append_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void make_segment(input logic [1:0] kind, input int key_n,
                                         input int val_n, input int pad_n,
                                         input logic [63:0] word);
        int body_n;
        body_n = (kind == tmd_pkg::TYPE_STR_STR) ? val_n :
                 (kind == tmd_pkg::TYPE_STR_INT) ? 4 : 8;
        if (kind == tmd_pkg::TYPE_COMMAND) begin
            push_word32(tmd_pkg::TAG_COMMAND);
            push_word32(tmd_pkg::MIN_LEN_COMMAND + pad_n);
            push_word32(word[31:0]);
        end else begin
            push_word32(tag_of(kind));
            push_word32(tmd_pkg::MIN_LEN_KEYED + key_n + body_n + pad_n);
            push_word32(key_n);
            // The size word of an int or double segment is not used.
            push_word32((kind == tmd_pkg::TYPE_STR_STR) ? 32'(val_n) : $urandom);
            push_random(key_n);
            if (kind == tmd_pkg::TYPE_STR_STR) push_random(val_n);
            else for (int i = 0; i < body_n; i++) append_byte(word[8*i +: 8]);
        end
        push_random(pad_n);
    endfunction

    function automatic void make_random_segment();
        int shape;
        int key_n;
        int val_n;
        int pad_n;
        shape = $urandom_range(0, 9);
        key_n = (shape == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        val_n = (shape == 1) ? $urandom_range(9, 24) : $urandom_range(0, 8);
        pad_n = (shape < 7) ? 0 : $urandom_range(1, 5);
        make_segment(2'($urandom_range(0, 3)), key_n, val_n, pad_n, {$urandom, $urandom});
    endfunction

    task automatic test_directed_segments();
        make_segment(tmd_pkg::TYPE_COMMAND, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame();
        make_segment(tmd_pkg::TYPE_STR_STR, 0, 0, 0, '0);
        send_frame();
        make_segment(tmd_pkg::TYPE_STR_STR, 1, 1, 1, '0);
        send_frame();
        make_segment(tmd_pkg::TYPE_STR_INT, 0, 0, 0, 64'h0000_0000_8000_00FF);
        send_frame();
        make_segment(tmd_pkg::TYPE_STR_DOUBLE, 1, 0, 0, 64'hFF00_FF00_00FF_0000);
        send_frame();
    endtask

    task automatic test_back_to_back();
        fast_mode = 1'b1;
        repeat (6) begin
            make_random_segment();
            send_frame();
        end
        fast_mode = 1'b0;
    endtask

    task automatic test_backpressure();
        fast_mode    = 1'b1;
        hold_pending = 1'b1;
        make_segment(tmd_pkg::TYPE_STR_STR, 40, 40, 2, '0);
        send_frame();
        fast_mode = 1'b0;
    endtask

    task automatic test_random_segments();
        int sent;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 15) == 0) fast_mode = !fast_mode;
            make_random_segment();
            sent += frame_bytes.size();
            send_frame();
        end
        fast_mode = 1'b0;
    endtask

    // An error stops the block until reset, so only one error case fits in a run.
    task automatic test_halt_on_error();
        int          variant;
        logic [1:0]  kind;
        logic [31:0] bad;
        int          key_n;
        int          extra;
        int          need;
        logic [31:0] val_field;
        variant = $urandom_range(0, 4);
        kind    = 2'($urandom_range(0, 2));
        case (variant)
            0: begin
                do begin
                    if ($urandom_range(0, 1) == 1) bad = $urandom;
                    else bad = tag_of(2'($urandom_range(0, 3))) ^ (32'd1 << $urandom_range(0, 31));
                end while (kind_of(bad) != KIND_UNKNOWN);
                push_word32(bad);
            end
            1: begin
                push_word32(tmd_pkg::TAG_COMMAND);
                push_word32($urandom_range(0, 11));
            end
            2: begin
                push_word32(tag_of(kind));
                push_word32($urandom_range(0, 15));
            end
            3: begin
                key_n     = $urandom_range(1, 8);
                val_field = (kind == tmd_pkg::TYPE_STR_STR) ? $urandom_range(0, 8) : $urandom;
                extra     = (kind == tmd_pkg::TYPE_STR_STR) ? int'(val_field)
                          : (kind == tmd_pkg::TYPE_STR_INT) ? 4 : 8;
                need      = 16 + key_n + extra;
                push_word32(tag_of(kind));
                push_word32(need - $urandom_range(1, key_n + extra));
                push_word32(key_n);
                push_word32(val_field);
            end
            default: begin
                // Sizes whose sum wraps in 32 bits must still be caught.
                push_word32(tag_of(kind));
                push_word32($urandom_range(16, 4096));
                push_word32(32'hFFFF_FFFF - $urandom_range(0, 15));
                push_word32(32'h8000_0000 | $urandom);
            end
        endcase
        push_random($urandom_range(8, 20));
        send_frame();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_segments();
        test_back_to_back();
        test_backpressure();
        test_random_segments();
        test_halt_on_error();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_records.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0 && awaited_records.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### typed_message_deframer_core.f
sv/tmd_pkg.sv
sv/tmd_front.sv
sv/tmd_queue.sv
sv/tmd_back.sv
sv/typed_message_deframer_core.sv
tb/sv/typed_message_deframer_core_tb.sv
